// File: rtl/lru_pkg.sv
// lru_pkg: shared types and constants for the timestamp lru victim select block
// item structs, action codes and default sizes; no dependencies
package lru_pkg;

   localparam int DEF_NUM_SETS    = 64;
   localparam int DEF_NUM_WAYS    = 8;
   localparam int DEF_STAMP_WIDTH = 32;

   localparam int ACTION_W = 2;
   localparam int SET_W    = 6;
   localparam int WAY_W    = 3;

   // sets and ways that the item fields can reach
   localparam int SET_SPAN = 1 << SET_W;
   localparam int WAY_SPAN = 1 << WAY_W;

   localparam logic [ACTION_W-1:0] ACT_INVALIDATE = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_STAMP      = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_VICTIM     = 2'd2;

   typedef struct packed {
      logic [ACTION_W-1:0] action;
      logic [SET_W-1:0]    set_index;
      logic [WAY_W-1:0]    way_index;
   } req_type;

   typedef struct packed {
      logic [WAY_W-1:0] victim_way;
      logic             victim_is_empty;
   } rsp_type;

endpackage

// File: rtl/lru_ram.sv
// lru_ram: generic single write port, single read port ram with registered read
// no dependencies
module lru_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                  clock,
   input  logic                                  wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                      wr_data,
   input  logic                                  rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                      rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/lru_scan.sv
// lru_scan: walks the stamps of one set, one way per cycle, keeping the oldest
// depends on lru_pkg for the result struct
module lru_scan #(
   parameter int NUM_WAYS    = lru_pkg::DEF_NUM_WAYS,
   parameter int STAMP_WIDTH = lru_pkg::DEF_STAMP_WIDTH
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            load,
   input  logic [NUM_WAYS*STAMP_WIDTH-1:0] row,
   output logic                            done,
   output lru_pkg::rsp_type                result
);
   import lru_pkg::*;

   localparam int IDX_W = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
   localparam int CNT_W = $clog2(NUM_WAYS + 1);
   localparam int ROW_W = NUM_WAYS * STAMP_WIDTH;

   logic                   active_ff, active_in;
   logic                   done_ff, done_in;
   logic [CNT_W-1:0]       cnt_ff, cnt_in;
   logic [IDX_W-1:0]       pos_ff, pos_in;
   logic [IDX_W-1:0]       best_idx_ff, best_idx_in;
   logic [STAMP_WIDTH-1:0] best_ff, best_in;
   logic [ROW_W-1:0]       rest_ff, rest_in;
   logic [STAMP_WIDTH-1:0] cand;

   assign cand = rest_ff[STAMP_WIDTH-1:0];

   always_comb begin
      active_in   = active_ff;
      done_in     = 1'b0;
      cnt_in      = cnt_ff;
      pos_in      = pos_ff;
      best_idx_in = best_idx_ff;
      best_in     = best_ff;
      rest_in     = rest_ff;
      if (load) begin
         best_in     = row[STAMP_WIDTH-1:0];
         best_idx_in = '0;
         rest_in     = row >> STAMP_WIDTH;
         pos_in      = IDX_W'(1);
         cnt_in      = CNT_W'(NUM_WAYS - 1);
         active_in   = (NUM_WAYS > 1);
         done_in     = (NUM_WAYS == 1);
      end else if (active_ff) begin
         if (cand < best_ff) begin
            best_in     = cand;
            best_idx_in = pos_ff;
         end
         rest_in = rest_ff >> STAMP_WIDTH;
         pos_in  = pos_ff + IDX_W'(1);
         cnt_in  = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            active_in = 1'b0;
            done_in   = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         done_ff   <= 1'b0;
      end else begin
         active_ff <= active_in;
         done_ff   <= done_in;
      end
      cnt_ff      <= cnt_in;
      pos_ff      <= pos_in;
      best_idx_ff <= best_idx_in;
      best_ff     <= best_in;
      rest_ff     <= rest_in;
   end

   logic [IDX_W+WAY_W-1:0] best_idx_wide;
   assign best_idx_wide = {{WAY_W{1'b0}}, best_idx_ff};

   assign done                   = done_ff;
   assign result.victim_way      = best_idx_wide[WAY_W-1:0];
   assign result.victim_is_empty = (best_ff == '0);

endmodule

// File: rtl/lru_timestamp_victim_select.sv
// Timestamp lru victim select. Each item (invalidate, stamp, or victim query) gives exactly one
// result, shown for one cycle on rsp_valid; the receiver cannot stall, so take it when it shows.
// Invalidate and stamp items go through ST_READ between accepts: the synchronous read of the set's
// stamp row is issued on accept, and in ST_READ the row is modified and written back. A victim query
// scans the row one way per cycle. busy is high while an item is in flight. Stamps live in a ram
// of one row per set; per-set valid flags cleared at reset make a never-written row read as all
// zero, so no clearing pass is needed after reset.
module lru_timestamp_victim_select #(
   parameter int NUM_SETS    = lru_pkg::DEF_NUM_SETS,
   parameter int NUM_WAYS    = lru_pkg::DEF_NUM_WAYS,
   parameter int STAMP_WIDTH = lru_pkg::DEF_STAMP_WIDTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  lru_pkg::req_type req_item,
   output logic             rsp_valid,
   output lru_pkg::rsp_type rsp_item
);
   import lru_pkg::*;

   localparam int REACH_SETS = (NUM_SETS < SET_SPAN) ? NUM_SETS : SET_SPAN;
   localparam int ADDR_W     = (REACH_SETS > 1) ? $clog2(REACH_SETS) : 1;
   localparam int IDX_W      = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
   localparam int ROW_W      = NUM_WAYS * STAMP_WIDTH;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_READ = 3'b010,
      ST_SCAN = 3'b100
   } state_type;

   state_type              state_ff, state_in;
   req_type                req_ff, req_in;
   logic [STAMP_WIDTH-1:0] time_ff, time_in;
   logic                   valid_ff [REACH_SETS];
   logic                   valid_in [REACH_SETS];
   logic                   rvalid_ff, rvalid_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_type                rsp_ff, rsp_in;

   logic                   rd_en, wr_en, scan_load, scan_done;
   logic [ADDR_W-1:0]      rd_addr, wr_addr;
   logic [ROW_W-1:0]       rd_data, row, wr_row;
   rsp_type                scan_rsp;
   logic                   new_set_ok, set_ok, way_ok;
   logic [IDX_W-1:0]       way_sel;

   assign new_set_ok = (32'(req_item.set_index) < NUM_SETS);
   assign set_ok     = (32'(req_ff.set_index) < NUM_SETS);
   assign way_ok     = (32'(req_ff.way_index) < NUM_WAYS);
   assign rd_addr    = ADDR_W'(req_item.set_index);
   assign wr_addr    = ADDR_W'(req_ff.set_index);
   assign way_sel    = IDX_W'(req_ff.way_index);
   assign row        = rvalid_ff ? rd_data : '0;

   lru_ram #(
      .WIDTH (ROW_W),
      .DEPTH (REACH_SETS)
   ) u_stamps (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_row),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   lru_scan #(
      .NUM_WAYS    (NUM_WAYS),
      .STAMP_WIDTH (STAMP_WIDTH)
   ) u_scan (
      .clock  (clock),
      .reset  (reset),
      .load   (scan_load),
      .row    (row),
      .done   (scan_done),
      .result (scan_rsp)
   );

   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      time_in      = time_ff;
      valid_in     = valid_ff;
      rvalid_in    = rvalid_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      rd_en        = 1'b0;
      wr_en        = 1'b0;
      wr_row       = row;
      scan_load    = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               req_in    = req_item;
               rd_en     = new_set_ok;
               rvalid_in = valid_ff[rd_addr];
               state_in  = ST_READ;
            end
         end
         ST_READ: begin
            rsp_valid_in = 1'b1;
            rsp_in       = '0;
            state_in     = ST_IDLE;
            case (req_ff.action)
               ACT_INVALIDATE: begin
                  if (set_ok && way_ok) begin
                     wr_row[way_sel*STAMP_WIDTH +: STAMP_WIDTH] = '0;
                     wr_en             = 1'b1;
                     valid_in[wr_addr] = 1'b1;
                  end
               end
               ACT_STAMP: begin
                  if (set_ok && way_ok) begin
                     wr_row[way_sel*STAMP_WIDTH +: STAMP_WIDTH] = time_ff;
                     wr_en             = 1'b1;
                     valid_in[wr_addr] = 1'b1;
                     if (time_ff != '1) begin
                        time_in = time_ff + STAMP_WIDTH'(1);
                     end
                  end
               end
               ACT_VICTIM: begin
                  if (set_ok) begin
                     scan_load    = 1'b1;
                     rsp_valid_in = 1'b0;
                     state_in     = ST_SCAN;
                  end
               end
               default: begin
                  rsp_in = '0;
               end
            endcase
         end
         ST_SCAN: begin
            if (scan_done) begin
               rsp_valid_in = 1'b1;
               rsp_in       = scan_rsp;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         time_ff      <= STAMP_WIDTH'(1);
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < REACH_SETS; i++) begin
            valid_ff[i] <= 1'b0;
         end
      end else begin
         state_ff     <= state_in;
         time_ff      <= time_in;
         rsp_valid_ff <= rsp_valid_in;
         valid_ff     <= valid_in;
      end
      req_ff    <= req_in;
      rvalid_ff <= rvalid_in;
      rsp_ff    <= rsp_in;
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

`ifndef SYNTHESIS
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("item accepted but block not busy");

   a_rsp_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("result strobe without an item in flight");

   a_non_victim_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && req_ff.action != ACT_VICTIM) |-> (rsp_item == '0))
      else $error("non-victim item gave nonzero result");

   a_time_nonzero: assert property (@(posedge clock) disable iff (reset)
      time_ff != '0)
      else $error("time counter reached zero");
`endif

endmodule

// File: tb/lru_victim_checker.sv
`timescale 1ns / 100ps
// lru_victim_checker: watches the item and result channels of the lru victim select block,
// predicts each result from its own copy of the stamp store and time counter, and compares
// depends on lru_pkg for the item structs and action codes
module lru_victim_checker #(
   parameter int NUM_SETS    = lru_pkg::DEF_NUM_SETS,
   parameter int NUM_WAYS    = lru_pkg::DEF_NUM_WAYS,
   parameter int STAMP_WIDTH = lru_pkg::DEF_STAMP_WIDTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic             busy,
   input  lru_pkg::req_type req_item,
   input  logic             rsp_valid,
   input  lru_pkg::rsp_type rsp_item,
   output int               mismatches,
   output int               outstanding,
   output int               results_checked,
   output int               empty_victims
);
   import lru_pkg::*;

   localparam logic [STAMP_WIDTH-1:0] STAMP_MAX = '1;

   logic [STAMP_WIDTH-1:0] stamp_mem [NUM_SETS][NUM_WAYS];
   logic [STAMP_WIDTH-1:0] now_stamp;
   rsp_type                victim_q[$];

   initial begin
      mismatches      = 0;
      outstanding     = 0;
      results_checked = 0;
      empty_victims   = 0;
   end

   function automatic rsp_type predict_access(input req_type it);
      rsp_type r;
      int      s;
      int      w;
      int      best;
      r = '0;
      s = int'(it.set_index);
      w = int'(it.way_index);
      if (s < NUM_SETS) begin
         case (it.action)
            ACT_INVALIDATE: begin
               if (w < NUM_WAYS) stamp_mem[s][w] = '0;
            end
            ACT_STAMP: begin
               if (w < NUM_WAYS) begin
                  stamp_mem[s][w] = now_stamp;
                  if (now_stamp != STAMP_MAX) now_stamp = now_stamp + 1'b1;
               end
            end
            ACT_VICTIM: begin
               best = 0;
               for (int k = 1; k < NUM_WAYS; k++) begin
                  if (stamp_mem[s][k] < stamp_mem[s][best]) best = k;
               end
               r.victim_way      = WAY_W'(best);
               r.victim_is_empty = (stamp_mem[s][best] == '0);
            end
            default: ;
         endcase
      end
      return r;
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         for (int s = 0; s < NUM_SETS; s++) begin
            for (int w = 0; w < NUM_WAYS; w++) stamp_mem[s][w] = '0;
         end
         now_stamp = STAMP_WIDTH'(1);
         victim_q.delete();
      end else begin
         if (start && !busy) victim_q.push_back(predict_access(req_item));
         if (rsp_valid) begin
            if (victim_q.size() == 0) begin
               if (mismatches < 10)
                  $display("%0t: result with no item pending: way %0d empty %0b", $time,
                           rsp_item.victim_way, rsp_item.victim_is_empty);
               mismatches++;
            end else begin
               want = victim_q.pop_front();
               results_checked++;
               if (want.victim_is_empty)
                  empty_victims++;
               if (rsp_item.victim_way !== want.victim_way ||
                   rsp_item.victim_is_empty !== want.victim_is_empty) begin
                  if (mismatches < 10)
                     $display("%0t: result %0d: expected way %0d empty %0b, got way %0d empty %0b",
                              $time, results_checked, want.victim_way, want.victim_is_empty,
                              rsp_item.victim_way, rsp_item.victim_is_empty);
                  mismatches++;
               end
            end
         end
      end
      outstanding <= victim_q.size();
   end

endmodule

// File: tb/lru_timestamp_victim_select_tb.sv
`timescale 1ns / 100ps
// lru_timestamp_victim_select_tb: directed and random invalidate, stamp, victim and unused-code items
// for the lru victim select block; checking is done by lru_victim_checker, needs lru_pkg
module lru_timestamp_victim_select_tb;
   import lru_pkg::*;

   localparam int NUM_SETS     = DEF_NUM_SETS;
   localparam int NUM_WAYS     = DEF_NUM_WAYS;
   localparam int STAMP_WIDTH  = DEF_STAMP_WIDTH;
   localparam int RANDOM_ITEMS = 1900;

   // action code with no meaning to the block
   localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;

   logic    clock    = 1'b0;
   logic    reset    = 1'b1;
   logic    start    = 1'b0;
   req_type req_item = '0;
   logic    busy;
   logic    rsp_valid;
   rsp_type rsp_item;

   int mismatches;
   int outstanding;
   int results_checked;
   int empty_victims;

   int  sent_count = 0;
   int  act_count[4] = '{0, 0, 0, 0};
   bit  quiet = 1'b0;

   always #1 clock = ~clock;

   lru_timestamp_victim_select #(
      .NUM_SETS(NUM_SETS),
      .NUM_WAYS(NUM_WAYS),
      .STAMP_WIDTH(STAMP_WIDTH)
   ) dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_item(req_item),
      .rsp_valid(rsp_valid),
      .rsp_item(rsp_item)
   );

   lru_victim_checker #(
      .NUM_SETS(NUM_SETS),
      .NUM_WAYS(NUM_WAYS),
      .STAMP_WIDTH(STAMP_WIDTH)
   ) victim_check (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_item(req_item),
      .rsp_valid(rsp_valid),
      .rsp_item(rsp_item),
      .mismatches(mismatches),
      .outstanding(outstanding),
      .results_checked(results_checked),
      .empty_victims(empty_victims)
   );

   function automatic logic [ACTION_W-1:0] ACT_ACTION_ANY();
      return ACTION_W'($urandom_range(0, 3));
   endfunction

   task automatic send_access(input logic [ACTION_W-1:0] act, input int set_idx,
                              input int way_idx);
      req_type it;
      int      gap;
      it.action    = act;
      it.set_index = SET_W'(set_idx);
      it.way_index = WAY_W'(way_idx);
      gap = quiet ? 0 : $urandom_range(0, 16);
      if (gap != 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start    <= 1'b1;
      req_item <= it;
      do @(posedge clock); while (busy);
      sent_count++;
      act_count[act]++;
   endtask

   // fill some ways of one set in random order, then mix queries, touches and invalidates
   task automatic fill_and_evict();
      int order[NUM_WAYS];
      int set_idx;
      int fill;
      int rounds;
      int j;
      int tmp;
      int pick;
      set_idx = $urandom_range(0, SET_SPAN - 1);
      for (int i = 0; i < NUM_WAYS; i++) order[i] = i;
      for (int i = NUM_WAYS - 1; i > 0; i--) begin
         j        = $urandom_range(0, i);
         tmp      = order[i];
         order[i] = order[j];
         order[j] = tmp;
      end
      fill = ($urandom_range(0, 2) == 0) ? $urandom_range(1, NUM_WAYS) : NUM_WAYS;
      for (int i = 0; i < fill; i++) send_access(ACT_STAMP, set_idx, order[i]);
      send_access(ACT_VICTIM, set_idx, $urandom_range(0, WAY_SPAN - 1));
      rounds = $urandom_range(1, 6);
      for (int i = 0; i < rounds; i++) begin
         pick = $urandom_range(0, 9);
         if (pick < 5)
            send_access(ACT_STAMP, set_idx, $urandom_range(0, WAY_SPAN - 1));
         else if (pick < 7)
            send_access(ACT_INVALIDATE, set_idx, $urandom_range(0, WAY_SPAN - 1));
         else
            send_access(ACT_VICTIM, set_idx, $urandom_range(0, WAY_SPAN - 1));
      end
      send_access(ACT_VICTIM, set_idx, $urandom_range(0, WAY_SPAN - 1));
   endtask

   initial begin
      int directed_count;
      int burst;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // empty set, then fill set 0 in way order
      send_access(ACT_VICTIM, 0, 0);
      for (int w = 0; w < NUM_WAYS; w++) send_access(ACT_STAMP, 0, w);
      send_access(ACT_VICTIM, 0, 7);
      send_access(ACT_STAMP, 0, 0);
      send_access(ACT_VICTIM, 0, 0);
      send_access(ACT_INVALIDATE, 0, 5);
      send_access(ACT_VICTIM, 0, 3);
      // unused action code leaves state alone
      send_access(ACT_UNUSED, 63, 7);
      send_access(ACT_UNUSED, 0, 0);
      send_access(ACT_VICTIM, 63, 7);
      send_access(ACT_STAMP, 63, 7);
      send_access(ACT_STAMP, 63, 0);
      send_access(ACT_VICTIM, 63, 0);
      send_access(ACT_INVALIDATE, 63, 7);
      send_access(ACT_VICTIM, 63, 0);
      directed_count = sent_count;

      while (sent_count < directed_count + RANDOM_ITEMS) begin
         quiet = ($urandom_range(0, 3) == 0);
         if ($urandom_range(0, 9) < 6) begin
            fill_and_evict();
         end else begin
            burst = $urandom_range(1, 8);
            for (int i = 0; i < burst; i++)
               send_access(ACT_ACTION_ANY(), $urandom_range(0, SET_SPAN - 1),
                           $urandom_range(0, WAY_SPAN - 1));
         end
      end
      start <= 1'b0;

      for (int i = 0; i < 1000 && outstanding != 0; i++) @(posedge clock);
      repeat (4 * NUM_WAYS) @(posedge clock);

      $display("sent %0d items: %0d stamps, %0d invalidates, %0d victim queries, %0d unused",
               sent_count, act_count[ACT_STAMP], act_count[ACT_INVALIDATE],
               act_count[ACT_VICTIM], act_count[ACT_UNUSED]);
      $display("checked %0d results, %0d of them naming an empty line",
               results_checked, empty_victims);
      if (mismatches == 0 && outstanding == 0) begin
         $display("PASS lru_timestamp_victim_select");
      end else begin
         $display("FAIL lru_timestamp_victim_select");
      end
      $finish;
   end

   initial begin
      #1000000;
      $display("FAIL lru_timestamp_victim_select");
      $finish;
   end

endmodule
